@@ rtl/cpust_pkg.sv @@
package cpust_pkg;

  // Vertex store depth and the widths that follow from it.
  localparam int MAX_VERTICES = 8;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Shared multiplier operand, product and accumulator widths.
  localparam int OPW  = 36;
  localparam int PW   = 2 * OPW;
  localparam int ACCW = 112;

  // Squared radius of the unit sphere in Q4.12 squared units.
  localparam logic signed [OPW-1:0] R2 = 36'sd16777216;

  // Result status codes.
  localparam logic [1:0] ST_MISS  = 2'd0;
  localparam logic [1:0] ST_HIT   = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  // Product shift codes for the accumulator.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_28 = 2'd2;
  localparam logic [1:0] SH_54 = 2'd3;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       neg;
    logic [1:0] sh;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec16_t;

  typedef struct packed {
    logic signed [16:0] z;
    logic signed [16:0] y;
    logic signed [16:0] x;
  } vec17_t;

  function automatic logic signed [OPW-1:0] sx16(input logic [15:0] v);
    return {{(OPW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [OPW-1:0] sx17(input logic [16:0] v);
    return {{(OPW-17){v[16]}}, v};
  endfunction

  // Component-wise difference a - b, one bit wider than the coordinates.
  function automatic vec17_t vsub(input vec16_t a, input vec16_t b);
    vec17_t r;
    r.x = {a.x[15], a.x} - {b.x[15], b.x};
    r.y = {a.y[15], a.y} - {b.y[15], b.y};
    r.z = {a.z[15], a.z} - {b.z[15], b.z};
    return r;
  endfunction

endpackage

@@ rtl/cpust_vram.sv @@
module cpust_vram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 48
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cpust_mac.sv @@
module cpust_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpust_pkg::mac_ctl_t                 ctl,
  input  logic signed [cpust_pkg::OPW-1:0]    a,
  input  logic signed [cpust_pkg::OPW-1:0]    b,
  output logic signed [cpust_pkg::ACCW-1:0]   acc
);

  cpust_pkg::mac_ctl_t                     ctl_r;
  logic signed [cpust_pkg::PW-1:0]         prod_r;
  logic signed [cpust_pkg::ACCW-1:0]       acc_r;
  logic signed [cpust_pkg::ACCW-1:0]       acc_nxt;
  logic signed [cpust_pkg::ACCW-1:0]       pext;
  logic signed [cpust_pkg::ACCW-1:0]       pshift;

  // Multiply stage; control travels alongside the product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    acc_r  <= acc_nxt;
  end

  // Accumulate stage: scale the product, then add or subtract it.
  always_comb begin
    pext = cpust_pkg::ACCW'(prod_r);
    case (ctl_r.sh)
      cpust_pkg::SH_0:  pshift = pext;
      cpust_pkg::SH_24: pshift = pext <<< 24;
      cpust_pkg::SH_28: pshift = pext <<< 28;
      cpust_pkg::SH_54: pshift = pext <<< 54;
      default:          pshift = pext;
    endcase
    acc_nxt = acc_r;
    if (ctl_r.en) begin
      acc_nxt = (ctl_r.clr ? '0 : acc_r) + (ctl_r.neg ? -pshift : pshift);
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/convex_polygon_unit_sphere_test_core.sv @@
// Convex polygon against unit sphere test.
// The input channel carries one vertex per item, counter-clockwise, as signed
// Q4.12 x, y, z; tlast marks the final vertex of a polygon and starts the test.
// The output channel returns one status item per polygon: 0 miss, 1 hit,
// 2 degenerate or fewer than three vertices, 3 more vertices than the store.
// Vertices load one per cycle into the vertex memory. After the final vertex
// the plane test and then the edge walk, one pass per vertex, run on one shared
// multiply-accumulate unit that is fed by one memory read port. A zero normal
// ends the test once the normal is formed, a plane beyond the sphere ends it
// before the edge walk, and overflow and short polygons skip the test.
// The input is not ready during the evaluation. The status sits in an output
// register: while the receiver stalls, vertices of the next polygon are still
// accepted, and only its final vertex's result waits for the slot to free.
// Reset empties the polygon being loaded and clears the output valid flag.
module convex_polygon_unit_sphere_test_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic        in_tlast,   // final_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status [1:0], zero [7:2]
);

  localparam int AW   = cpust_pkg::AW;
  localparam int CW   = cpust_pkg::CW;
  localparam int OPW  = cpust_pkg::OPW;
  localparam int ACCW = cpust_pkg::ACCW;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_EDGE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [4:0] NS_ZCHK  = 5'd8;
  localparam logic [4:0] NS_PLANE = 5'd20;
  localparam logic [4:0] ES_LAST  = 5'd31;

  localparam logic [CW-1:0] CNT_FULL = CW'(cpust_pkg::MAX_VERTICES);
  localparam logic [CW-1:0] CNT_MIN  = CW'(2);

  logic [1:0]              state_r, state_nxt;
  logic [4:0]              step_r, step_nxt;
  logic [CW-1:0]           cnt_r;
  logic                    ovf_r;
  logic                    ovalid_r;
  logic [1:0]              odata_r;
  logic [1:0]              res_r;

  cpust_pkg::vec16_t       in_v, rd_v, v0_r, p_r, q_r;
  cpust_pkg::vec17_t       d1_r, d2_r, e_r;
  logic [AW-1:0]           last_r, idx_r, idx_next, raddr;
  logic signed [OPW-1:0]   nx_r, ny_r, nz_r;
  logic signed [53:0]      pd_r;
  logic [53:0]             pm;
  logic signed [OPW-1:0]   ee_r, pe_r, pp_r, qq_r, cx_r, cy_r, cz_r;
  logic                    dle_r, near_r, outs_r;

  logic                    in_acc;
  logic                    mem_we;
  logic [47:0]             rdata;
  cpust_pkg::mac_ctl_t     ctl;
  logic signed [OPW-1:0]   mac_a, mac_b;
  logic signed [ACCW-1:0]  acc;
  logic signed [OPW-1:0]   hi_op, lo_op;
  logic                    acc_pos, n_zero;
  logic signed [36:0]      pe_ee;
  logic                    near_new, out_new;

  assign in_v      = cpust_pkg::vec16_t'(in_tdata);
  assign rd_v      = cpust_pkg::vec16_t'(rdata);
  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign mem_we    = in_acc && (cnt_r < CNT_FULL);

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'b0, odata_r};

  // Edge endpoint addresses: start vertex, then its successor with wraparound.
  assign idx_next = (idx_r == last_r) ? '0 : AW'(idx_r + 1'b1);
  assign raddr    = (step_r == 5'd1) ? idx_next : idx_r;

  cpust_vram #(
    .DEPTH (cpust_pkg::MAX_VERTICES),
    .WIDTH (48)
  ) u_vram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cpust_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  // Plane distance split into high and low halves for the squaring.
  assign pm    = pd_r[53] ? 54'(-pd_r) : 54'(pd_r);
  assign hi_op = OPW'(pm[53:27]);
  assign lo_op = OPW'(pm[26:0]);

  assign acc_pos = !acc[ACCW-1] && (acc != '0);
  assign n_zero  = (nx_r == '0) && (ny_r == '0) && (nz_r == '0);

  // Nearest-point classification of the current edge.
  assign pe_ee = 37'(pe_r) + 37'(ee_r);
  always_comb begin
    if ((!pe_r[OPW-1] && pe_r != '0) || ee_r == '0) begin
      near_new = (pp_r <= cpust_pkg::R2);
    end else if (pe_ee < 0) begin
      near_new = (qq_r <= cpust_pkg::R2);
    end else begin
      near_new = dle_r;
    end
  end
  assign out_new = acc[ACCW-1];

  // Multiply-accumulate program: at most one product issued per step.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    ctl   = '0;
    case (state_r)
      S_NORM: begin
        case (step_r)
          5'd0: begin
            mac_a = cpust_pkg::sx17(d1_r.y); mac_b = cpust_pkg::sx17(d2_r.z);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd1: begin
            mac_a = cpust_pkg::sx17(d1_r.z); mac_b = cpust_pkg::sx17(d2_r.y);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_0};
          end
          5'd2: begin
            mac_a = cpust_pkg::sx17(d1_r.z); mac_b = cpust_pkg::sx17(d2_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd3: begin
            mac_a = cpust_pkg::sx17(d1_r.x); mac_b = cpust_pkg::sx17(d2_r.z);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_0};
          end
          5'd4: begin
            mac_a = cpust_pkg::sx17(d1_r.x); mac_b = cpust_pkg::sx17(d2_r.y);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd5: begin
            mac_a = cpust_pkg::sx17(d1_r.y); mac_b = cpust_pkg::sx17(d2_r.x);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_0};
          end
          5'd8: begin
            mac_a = nx_r; mac_b = cpust_pkg::sx16(v0_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd9: begin
            mac_a = ny_r; mac_b = cpust_pkg::sx16(v0_r.y);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd10: begin
            mac_a = nz_r; mac_b = cpust_pkg::sx16(v0_r.z);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd13: begin
            mac_a = hi_op; mac_b = hi_op;
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_54};
          end
          5'd14: begin
            mac_a = hi_op; mac_b = lo_op;
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_28};
          end
          5'd15: begin
            mac_a = lo_op; mac_b = lo_op;
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd16: begin
            mac_a = nx_r; mac_b = nx_r;
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_24};
          end
          5'd17: begin
            mac_a = ny_r; mac_b = ny_r;
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_24};
          end
          5'd18: begin
            mac_a = nz_r; mac_b = nz_r;
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_24};
          end
          default: begin
            ctl = '0;
          end
        endcase
      end
      S_EDGE: begin
        case (step_r)
          5'd3: begin
            mac_a = cpust_pkg::sx17(e_r.x); mac_b = cpust_pkg::sx17(e_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd4: begin
            mac_a = cpust_pkg::sx17(e_r.y); mac_b = cpust_pkg::sx17(e_r.y);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd5: begin
            mac_a = cpust_pkg::sx17(e_r.z); mac_b = cpust_pkg::sx17(e_r.z);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd6: begin
            mac_a = cpust_pkg::sx16(p_r.x); mac_b = cpust_pkg::sx17(e_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd7: begin
            mac_a = cpust_pkg::sx16(p_r.y); mac_b = cpust_pkg::sx17(e_r.y);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd8: begin
            mac_a = cpust_pkg::sx16(p_r.z); mac_b = cpust_pkg::sx17(e_r.z);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd9: begin
            mac_a = cpust_pkg::sx16(p_r.x); mac_b = cpust_pkg::sx16(p_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd10: begin
            mac_a = cpust_pkg::sx16(p_r.y); mac_b = cpust_pkg::sx16(p_r.y);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd11: begin
            mac_a = cpust_pkg::sx16(p_r.z); mac_b = cpust_pkg::sx16(p_r.z);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd12: begin
            mac_a = cpust_pkg::sx16(q_r.x); mac_b = cpust_pkg::sx16(q_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd13: begin
            mac_a = cpust_pkg::sx16(q_r.y); mac_b = cpust_pkg::sx16(q_r.y);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd14: begin
            mac_a = cpust_pkg::sx16(q_r.z); mac_b = cpust_pkg::sx16(q_r.z);
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd15: begin
            mac_a = cpust_pkg::sx16(p_r.y); mac_b = cpust_pkg::sx17(e_r.z);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd16: begin
            mac_a = cpust_pkg::sx16(p_r.z); mac_b = cpust_pkg::sx17(e_r.y);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_0};
          end
          5'd17: begin
            mac_a = cpust_pkg::sx16(p_r.z); mac_b = cpust_pkg::sx17(e_r.x);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd18: begin
            mac_a = cpust_pkg::sx16(p_r.x); mac_b = cpust_pkg::sx17(e_r.z);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_0};
          end
          5'd19: begin
            mac_a = cpust_pkg::sx16(p_r.x); mac_b = cpust_pkg::sx17(e_r.y);
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd20: begin
            mac_a = cpust_pkg::sx16(p_r.y); mac_b = cpust_pkg::sx17(e_r.x);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_0};
          end
          5'd23: begin
            mac_a = cx_r; mac_b = cx_r;
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd24: begin
            mac_a = cy_r; mac_b = cy_r;
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd25: begin
            mac_a = cz_r; mac_b = cz_r;
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd26: begin
            mac_a = ee_r; mac_b = OPW'(1);
            ctl = '{1'b1, 1'b0, 1'b1, cpust_pkg::SH_24};
          end
          5'd27: begin
            mac_a = nx_r; mac_b = cx_r;
            ctl = '{1'b1, 1'b1, 1'b0, cpust_pkg::SH_0};
          end
          5'd28: begin
            mac_a = ny_r; mac_b = cy_r;
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          5'd29: begin
            mac_a = nz_r; mac_b = cz_r;
            ctl = '{1'b1, 1'b0, 1'b0, cpust_pkg::SH_0};
          end
          default: begin
            ctl = '0;
          end
        endcase
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_tlast) begin
          step_nxt = '0;
          if (ovf_r || cnt_r == CNT_FULL || cnt_r < CNT_MIN) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        step_nxt = step_r + 5'd1;
        if (step_r == NS_ZCHK && n_zero) begin
          state_nxt = S_DONE;
        end else if (step_r == NS_PLANE) begin
          step_nxt  = '0;
          state_nxt = acc_pos ? S_DONE : S_EDGE;
        end
      end
      S_EDGE: begin
        step_nxt = step_r + 5'd1;
        if (step_r == ES_LAST && idx_r == last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      step_r   <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (in_acc) begin
        if (in_tlast) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else if (cnt_r < CNT_FULL) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (state_r == S_DONE && (!ovalid_r || out_tready)) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!ovalid_r || out_tready)) begin
      odata_r <= res_r;
    end
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r == '0) begin
            v0_r <= in_v;
          end
          if (cnt_r == CW'(1)) begin
            d1_r <= cpust_pkg::vsub(in_v, v0_r);
          end
          if (in_tlast) begin
            d2_r   <= cpust_pkg::vsub(in_v, v0_r);
            last_r <= cnt_r[AW-1:0];
            res_r  <= (ovf_r || cnt_r == CNT_FULL) ? cpust_pkg::ST_OVF : cpust_pkg::ST_DEGEN;
          end
        end
      end
      S_NORM: begin
        case (step_r)
          5'd3:  nx_r <= acc[OPW-1:0];
          5'd5:  ny_r <= acc[OPW-1:0];
          5'd7:  nz_r <= acc[OPW-1:0];
          5'd12: pd_r <= acc[53:0];
          default: begin
          end
        endcase
        if (step_r == NS_ZCHK && n_zero) begin
          res_r <= cpust_pkg::ST_DEGEN;
        end
        if (step_r == NS_PLANE) begin
          res_r  <= cpust_pkg::ST_MISS;
          idx_r  <= '0;
          near_r <= 1'b0;
          outs_r <= 1'b0;
        end
      end
      S_EDGE: begin
        case (step_r)
          5'd1: p_r <= rd_v;
          5'd2: begin
            q_r <= rd_v;
            e_r <= cpust_pkg::vsub(rd_v, p_r);
          end
          5'd7:  ee_r <= acc[OPW-1:0];
          5'd10: pe_r <= acc[OPW-1:0];
          5'd13: pp_r <= acc[OPW-1:0];
          5'd16: qq_r <= acc[OPW-1:0];
          5'd18: cx_r <= acc[OPW-1:0];
          5'd20: cy_r <= acc[OPW-1:0];
          5'd22: cz_r <= acc[OPW-1:0];
          5'd28: dle_r <= !acc_pos;
          default: begin
          end
        endcase
        if (step_r == ES_LAST) begin
          near_r <= near_r || near_new;
          outs_r <= outs_r || out_new;
          idx_r  <= idx_next;
          if (near_r || near_new) begin
            res_r <= cpust_pkg::ST_HIT;
          end else if (outs_r || out_new) begin
            res_r <= cpust_pkg::ST_MISS;
          end else begin
            res_r <= cpust_pkg::ST_HIT;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/cpust_chk.sv @@
module cpust_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Loading continues after a vertex that is not the final one.
  a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input stalled in the middle of a polygon");

  // The final vertex starts the test, which holds off the next vertex.
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input ready right after the final vertex");

endmodule

bind convex_polygon_unit_sphere_test_core cpust_chk u_cpust_chk (.*);

@@ dv/convex_polygon_unit_sphere_test_core_tb.sv @@
module convex_polygon_unit_sphere_test_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = cpust_pkg::MAX_VERTICES;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int STALL_CYCLES = 3000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } vertex_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  convex_polygon_unit_sphere_test_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Stimulus and expected status queues.
  vertex_item_t pending_vertices[$];
  logic [1:0]   status_expected[$];

  // Predictor copy of the polygon being loaded.
  longint poly_x[DEPTH];
  longint poly_y[DEPTH];
  longint poly_z[DEPTH];
  int     poly_count = 0;
  bit     poly_overflow = 0;

  int  mismatches = 0;
  int  idle_in_pct = 0;
  int  idle_out_pct = 0;
  bit  hold_receiver = 0;
  bit  stall_request = 0;
  int  stall_count = 0;
  bit  sender_paused = 0;
  longint cycle_count = 0;

  function automatic longint dot3(longint ax, longint ay, longint az,
                                  longint bx, longint by, longint bz);
    return ax * bx + ay * by + az * bz;
  endfunction

  // Sum of squares of three 64-bit values, exact in 128 bits.
  function automatic logic [127:0] sq_sum(longint a, longint b, longint c);
    logic signed [127:0] sa, sb, sc;
    sa = a; sb = b; sc = c;
    return sa * sa + sb * sb + sc * sc;
  endfunction

  // Full polygon test on n stored vertices.
  function automatic logic [1:0] polygon_status(int n);
    longint ex, ey, ez, fx, fy, fz, nx, ny, nz, pd, ee, tp;
    longint px, py, pz, qx, qy, qz, cx, cy, cz, gx, gy, gz;
    logic [127:0] lhs, rhs;
    logic signed [127:0] s;
    bit near_edge;
    int j;
    ex = poly_x[1] - poly_x[0]; ey = poly_y[1] - poly_y[0]; ez = poly_z[1] - poly_z[0];
    fx = poly_x[n-1] - poly_x[0]; fy = poly_y[n-1] - poly_y[0]; fz = poly_z[n-1] - poly_z[0];
    nx = ey * fz - ez * fy;
    ny = ez * fx - ex * fz;
    nz = ex * fy - ey * fx;
    if (nx == 0 && ny == 0 && nz == 0) return cpust_pkg::ST_DEGEN;
    pd = dot3(nx, ny, nz, poly_x[0], poly_y[0], poly_z[0]);
    lhs = sq_sum(pd, 0, 0);
    rhs = sq_sum(nx, ny, nz) << 24;
    if (lhs > rhs) return cpust_pkg::ST_MISS;
    // Nearest point of each edge against the sphere.
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      px = poly_x[i]; py = poly_y[i]; pz = poly_z[i];
      qx = poly_x[j]; qy = poly_y[j]; qz = poly_z[j];
      ex = qx - px; ey = qy - py; ez = qz - pz;
      ee = dot3(ex, ey, ez, ex, ey, ez);
      tp = -dot3(px, py, pz, ex, ey, ez);
      if (tp < 0 || ee == 0)
        near_edge = dot3(px, py, pz, px, py, pz) <= 64'sd16777216;
      else if (tp > ee)
        near_edge = dot3(qx, qy, qz, qx, qy, qz) <= 64'sd16777216;
      else begin
        cx = py * ez - pz * ey; cy = pz * ex - px * ez; cz = px * ey - py * ex;
        lhs = sq_sum(cx, cy, cz);
        rhs = 128'(ee) << 24;
        near_edge = lhs <= rhs;
      end
      if (near_edge) return cpust_pkg::ST_HIT;
    end
    // Foot of the origin on the inner side of every edge.
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      px = poly_x[i]; py = poly_y[i]; pz = poly_z[i];
      ex = poly_x[j] - px; ey = poly_y[j] - py; ez = poly_z[j] - pz;
      gx = ey * pz - ez * py; gy = ez * px - ex * pz; gz = ex * py - ey * px;
      s = 128'(nx) * 128'(gx) + 128'(ny) * 128'(gy) + 128'(nz) * 128'(gz);
      if (s > 0) return cpust_pkg::ST_MISS;
    end
    return cpust_pkg::ST_HIT;
  endfunction

  // Predictor step for one accepted vertex.
  task automatic predict_vertex(vertex_item_t v);
    logic [1:0] st;
    if (poly_count < DEPTH) begin
      poly_x[poly_count] = v.x;
      poly_y[poly_count] = v.y;
      poly_z[poly_count] = v.z;
      poly_count++;
    end else
      poly_overflow = 1;
    if (v.last) begin
      if (poly_overflow) st = cpust_pkg::ST_OVF;
      else if (poly_count < 3) st = cpust_pkg::ST_DEGEN;
      else st = polygon_status(poly_count);
      status_expected.insert(status_expected.size(), st);
      poly_count = 0;
      poly_overflow = 0;
    end
  endtask

  // Driver: offers items from the pending queue and feeds each accepted one to the predictor.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) predict_vertex('{$signed(in_tdata[15:0]), $signed(in_tdata[31:16]),
                                        $signed(in_tdata[47:32]), in_tlast});
        if (pending_vertices.size() > 0 && !sender_paused &&
            $urandom_range(99) >= idle_in_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_vertices[0].z, pending_vertices[0].y, pending_vertices[0].x};
          in_tlast  <= pending_vertices[0].last;
          void'(pending_vertices.pop_front());
        end else
          in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver hold-off: once requested, ready stays low for a counted stretch.
  always @(posedge clk) begin
    if (stall_count > 0) begin
      stall_count   <= stall_count - 1;
      hold_receiver <= (stall_count > 1);
    end else if (stall_request) begin
      stall_count   <= STALL_CYCLES;
      hold_receiver <= 1'b1;
    end
  end

  // Monitor: checks every accepted status item and drives the receiver ready.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (status_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected status item %0d", out_tdata[1:0]);
        end else begin
          if (out_tdata[1:0] !== status_expected[0] || out_tdata[7:2] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Status mismatch: expected %0d, got 0x%02h", status_expected[0], out_tdata);
          end
          void'(status_expected.pop_front());
        end
      end
      out_tready <= !hold_receiver && ($urandom_range(99) >= idle_out_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic vertex_item_t make_vertex(int x, int y, int z, bit last);
    vertex_item_t v;
    v.x = x; v.y = y; v.z = z; v.last = last;
    return v;
  endfunction

  // Appends one vertex to the pending queue.
  task automatic add_vertex(int x, int y, int z, bit last);
    pending_vertices.insert(pending_vertices.size(), make_vertex(x, y, z, last));
  endtask

  function automatic int rand_coord(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // Random convex polygon: points on a planar ellipse in counter-clockwise order.
  task automatic queue_random_polygon();
    int n, span, cx, cy, cz, ux, uy, uz, wx, wy, wz;
    real ang;
    n = $urandom_range(3, DEPTH);
    span = ($urandom_range(3) == 0) ? 30000 : 8000;
    cx = rand_coord(span / 2); cy = rand_coord(span / 2); cz = rand_coord(span / 2);
    ux = rand_coord(span / 2); uy = rand_coord(span / 2); uz = rand_coord(span / 2);
    wx = rand_coord(span / 2); wy = rand_coord(span / 2); wz = rand_coord(span / 2);
    for (int i = 0; i < n; i++) begin
      ang = 6.2831853 * i / n;
      add_vertex(
        cx + int'($cos(ang) * ux + $sin(ang) * wx) / 2,
        cy + int'($cos(ang) * uy + $sin(ang) * wy) / 2,
        cz + int'($cos(ang) * uz + $sin(ang) * wz) / 2, i == n - 1);
    end
  endtask

  task automatic queue_noise_polygon();
    int n;
    n = $urandom_range(1, DEPTH + 3);
    for (int i = 0; i < n; i++)
      add_vertex($urandom_range(65535) - 32768,
        $urandom_range(65535) - 32768, $urandom_range(65535) - 32768, i == n - 1);
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() > 0 || in_tvalid || status_expected.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int queued;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: triangle through the sphere, far plane, extremes, short and long polygons.
    add_vertex(-8192, -8192, 0, 0);
    add_vertex(8192, -8192, 0, 0);
    add_vertex(0, 8192, 0, 1);
    add_vertex(-8192, -8192, 12000, 0);
    add_vertex(8192, -8192, 12000, 0);
    add_vertex(0, 8192, 12000, 1);
    add_vertex(-32768, -32768, -32768, 0);
    add_vertex(32767, 32767, -32768, 0);
    add_vertex(32767, -32768, 32767, 1);
    add_vertex(100, 100, 100, 1);
    add_vertex(1, 2, 3, 0);
    add_vertex(4, 5, 6, 1);
    // Zero normal from repeated vertices.
    add_vertex(5000, 0, 0, 0);
    add_vertex(5000, 0, 0, 0);
    add_vertex(0, 5000, 0, 1);
    // Repeated vertex near the sphere, edge of zero length.
    add_vertex(2000, 0, 3000, 0);
    add_vertex(9000, 0, 3000, 0);
    add_vertex(9000, 0, 3000, 0);
    add_vertex(9000, 9000, 3000, 1);
    // Too many vertices.
    for (int i = 0; i < DEPTH + 2; i++)
      add_vertex(i * 300, i * i * 50, 2000, i == DEPTH + 1);
    wait_drained();

    // Random phases with changing idle rates.
    for (int phase = 0; phase < 3; phase++) begin
      idle_in_pct  = (phase == 0) ? 18 : (phase == 1) ? 60 : 0;
      idle_out_pct = (phase == 0) ? 60 : (phase == 1) ? 18 : 0;
      queued = 0;
      while (queued < 230) begin
        queued = pending_vertices.size() + queued;
        if ($urandom_range(9) < 8) queue_random_polygon();
        else queue_noise_polygon();
        queued = queued + 0;
        queued = 0;
        foreach (pending_vertices[k]) queued++;
        if (queued >= 230) break;
      end
      if (phase == 1) begin
        // Long receiver stall while the sender keeps offering items.
        stall_request = 1'b1;
        while (!hold_receiver) @(posedge clk);
        stall_request = 1'b0;
        while (hold_receiver) @(posedge clk);
      end
      // The sender pauses part way until every status has come back.
      repeat (300) @(posedge clk);
      sender_paused = 1;
      while (in_tvalid || status_expected.size() > 0) @(posedge clk);
      sender_paused = 0;
      wait_drained();
    end

    repeat (400) @(posedge clk);
    if (mismatches == 0 && status_expected.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
